FILE: rtl/itsp_pkg.sv
// shared types and character/phase constants for the timestamp stream parser
package itsp_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        has_time;
      logic        has_zone;
      logic        zone_was_z;
      logic signed [19:0] offset_seconds;
   } rsp_type;

   // parse phases
   localparam logic [4:0] PH_LEAD     = 5'd0;
   localparam logic [4:0] PH_Y1       = 5'd1;
   localparam logic [4:0] PH_Y2       = 5'd2;
   localparam logic [4:0] PH_Y3       = 5'd3;
   localparam logic [4:0] PH_DASH1    = 5'd4;
   localparam logic [4:0] PH_MO0      = 5'd5;
   localparam logic [4:0] PH_MO1      = 5'd6;
   localparam logic [4:0] PH_DASH2    = 5'd7;
   localparam logic [4:0] PH_DA0      = 5'd8;
   localparam logic [4:0] PH_DA1      = 5'd9;
   localparam logic [4:0] PH_DATE_END = 5'd10;
   localparam logic [4:0] PH_HR0      = 5'd11;
   localparam logic [4:0] PH_HR1      = 5'd12;
   localparam logic [4:0] PH_COL1     = 5'd13;
   localparam logic [4:0] PH_MI0      = 5'd14;
   localparam logic [4:0] PH_MI1      = 5'd15;
   localparam logic [4:0] PH_COL2     = 5'd16;
   localparam logic [4:0] PH_SE0      = 5'd17;
   localparam logic [4:0] PH_SE1      = 5'd18;
   localparam logic [4:0] PH_TIME_END = 5'd19;
   localparam logic [4:0] PH_FRAC     = 5'd20;
   localparam logic [4:0] PH_ZH0      = 5'd21;
   localparam logic [4:0] PH_ZH1      = 5'd22;
   localparam logic [4:0] PH_ZH_END   = 5'd23;
   localparam logic [4:0] PH_ZM0      = 5'd24;
   localparam logic [4:0] PH_ZM1      = 5'd25;
   localparam logic [4:0] PH_DONE     = 5'd26;
   localparam logic [4:0] PH_TRAIL    = 5'd27;
   localparam logic [4:0] PH_ERR      = 5'd28;

   // status flag bits
   localparam int FL_TIME = 0;
   localparam int FL_ZONE = 1;
   localparam int FL_Z    = 2;
   localparam int FL_NEG  = 3;

   // characters
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Z_UP  = 8'h5A;
   localparam logic [7:0] CH_Z_LO  = 8'h7A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [19:0] SEC_PER_HOUR = 20'd3600;
   localparam logic [19:0] SEC_PER_MIN  = 20'd60;

endpackage

FILE: rtl/itsp_parse.sv
// per-byte parse state, field accumulators and result formation
module itsp_parse (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  itsp_pkg::req_type in_data,
   output itsp_pkg::rsp_type result
);

   logic [4:0]  phase_ff,  phase_in;
   logic [13:0] year_ff,   year_in;
   logic [6:0]  month_ff,  month_in;
   logic [6:0]  day_ff,    day_in;
   logic [6:0]  hour_ff,   hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic [6:0]  zh_ff,     zh_in;
   logic [6:0]  zm_ff,     zm_in;
   logic [3:0]  flags_ff,  flags_in;

   logic [7:0]  c;
   logic        dg;
   logic        sp;
   logic [3:0]  d;
   logic [17:0] year_prod;
   logic [19:0] mag;

   function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] dv);
      logic [10:0] t;
      t = {4'd0, a} * 11'd10 + {7'd0, dv};
      return t[6:0];
   endfunction

   function automatic logic is_complete(input logic [4:0] ph);
      return ph == itsp_pkg::PH_DATE_END || ph == itsp_pkg::PH_TIME_END ||
             ph == itsp_pkg::PH_FRAC     || ph == itsp_pkg::PH_ZH_END   ||
             ph == itsp_pkg::PH_DONE     || ph == itsp_pkg::PH_TRAIL;
   endfunction

   // phase after a zone-start character
   function automatic logic [4:0] zone_phase(input logic [7:0] ch);
      logic [4:0] ph;
      ph = itsp_pkg::PH_ERR;
      if (ch == itsp_pkg::CH_Z_UP || ch == itsp_pkg::CH_Z_LO) begin
         ph = itsp_pkg::PH_DONE;
      end else if (ch == itsp_pkg::CH_PLUS || ch == itsp_pkg::CH_MINUS) begin
         ph = itsp_pkg::PH_ZH0;
      end
      return ph;
   endfunction

   // flag bits set by a zone-start character
   function automatic logic [3:0] zone_flags(input logic [7:0] ch);
      logic [3:0] f;
      f = 4'd0;
      if (ch == itsp_pkg::CH_Z_UP || ch == itsp_pkg::CH_Z_LO) begin
         f[itsp_pkg::FL_ZONE] = 1'b1;
         f[itsp_pkg::FL_Z]    = 1'b1;
      end else if (ch == itsp_pkg::CH_PLUS) begin
         f[itsp_pkg::FL_ZONE] = 1'b1;
      end else if (ch == itsp_pkg::CH_MINUS) begin
         f[itsp_pkg::FL_ZONE] = 1'b1;
         f[itsp_pkg::FL_NEG]  = 1'b1;
      end
      return f;
   endfunction

   assign c  = in_data.char_code;
   assign dg = (c >= itsp_pkg::CH_ZERO) && (c <= itsp_pkg::CH_NINE);
   assign sp = (c == itsp_pkg::CH_SPACE) || ((c >= itsp_pkg::CH_TAB) && (c <= itsp_pkg::CH_CR));
   assign d  = dg ? c[3:0] : 4'd0;
   assign year_prod = {4'd0, year_ff} * 18'd10 + {14'd0, d};

   always_comb begin
      phase_in  = phase_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      zh_in     = zh_ff;
      zm_in     = zm_ff;
      flags_in  = flags_ff;
      result    = '0;
      mag       = '0;
      if (take) begin
         if (phase_ff == itsp_pkg::PH_ERR) begin
            phase_in = itsp_pkg::PH_ERR;
         end else if (sp) begin
            if (phase_ff == itsp_pkg::PH_LEAD) begin
               phase_in = itsp_pkg::PH_LEAD;
            end else begin
               phase_in = is_complete(phase_ff) ? itsp_pkg::PH_TRAIL : itsp_pkg::PH_ERR;
            end
         end else begin
            case (phase_ff)
               itsp_pkg::PH_LEAD, itsp_pkg::PH_Y1, itsp_pkg::PH_Y2, itsp_pkg::PH_Y3: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     year_in  = year_prod[13:0];
                     phase_in = (phase_ff == itsp_pkg::PH_Y3) ? itsp_pkg::PH_DASH1
                                                              : phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_DASH1: begin
                  phase_in = (c == itsp_pkg::CH_MINUS) ? itsp_pkg::PH_MO0 : itsp_pkg::PH_ERR;
               end
               itsp_pkg::PH_MO0, itsp_pkg::PH_MO1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     month_in = acc2(month_ff, d);
                     phase_in = phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_DASH2: begin
                  phase_in = (c == itsp_pkg::CH_MINUS) ? itsp_pkg::PH_DA0 : itsp_pkg::PH_ERR;
               end
               itsp_pkg::PH_DA0, itsp_pkg::PH_DA1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     day_in   = acc2(day_ff, d);
                     phase_in = phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_DATE_END: begin
                  if (c == itsp_pkg::CH_T) begin
                     flags_in[itsp_pkg::FL_TIME] = 1'b1;
                     phase_in = itsp_pkg::PH_HR0;
                  end else begin
                     flags_in = flags_ff | zone_flags(c);
                     phase_in = zone_phase(c);
                  end
               end
               itsp_pkg::PH_HR0, itsp_pkg::PH_HR1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     hour_in  = acc2(hour_ff, d);
                     phase_in = phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_COL1: begin
                  phase_in = (c == itsp_pkg::CH_COLON) ? itsp_pkg::PH_MI0 : itsp_pkg::PH_ERR;
               end
               itsp_pkg::PH_MI0, itsp_pkg::PH_MI1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     minute_in = acc2(minute_ff, d);
                     phase_in  = phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_COL2: begin
                  phase_in = (c == itsp_pkg::CH_COLON) ? itsp_pkg::PH_SE0 : itsp_pkg::PH_ERR;
               end
               itsp_pkg::PH_SE0, itsp_pkg::PH_SE1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     second_in = acc2(second_ff, d);
                     phase_in  = phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_TIME_END: begin
                  if (c == itsp_pkg::CH_DOT) begin
                     phase_in = itsp_pkg::PH_FRAC;
                  end else begin
                     flags_in = flags_ff | zone_flags(c);
                     phase_in = zone_phase(c);
                  end
               end
               itsp_pkg::PH_FRAC: begin
                  if (dg) begin
                     phase_in = itsp_pkg::PH_FRAC;
                  end else begin
                     flags_in = flags_ff | zone_flags(c);
                     phase_in = zone_phase(c);
                  end
               end
               itsp_pkg::PH_ZH0, itsp_pkg::PH_ZH1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     zh_in    = acc2(zh_ff, d);
                     phase_in = phase_ff + 5'd1;
                  end
               end
               itsp_pkg::PH_ZH_END: begin
                  if (c == itsp_pkg::CH_COLON) begin
                     phase_in = itsp_pkg::PH_ZM0;
                  end else if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     zm_in    = acc2(zm_ff, d);
                     phase_in = itsp_pkg::PH_ZM1;
                  end
               end
               itsp_pkg::PH_ZM0: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     zm_in    = acc2(zm_ff, d);
                     phase_in = itsp_pkg::PH_ZM1;
                  end
               end
               itsp_pkg::PH_ZM1: begin
                  if (!dg) begin
                     phase_in = itsp_pkg::PH_ERR;
                  end else begin
                     zm_in    = acc2(zm_ff, d);
                     phase_in = itsp_pkg::PH_DONE;
                  end
               end
               default: begin
                  phase_in = itsp_pkg::PH_ERR;
               end
            endcase
         end

         if (in_data.last_char) begin
            // end of string: form the result, then start over
            mag = {13'd0, zh_in} * itsp_pkg::SEC_PER_HOUR +
                  {13'd0, zm_in} * itsp_pkg::SEC_PER_MIN;
            if (is_complete(phase_in)) begin
               result.valid_res  = 1'b1;
               result.year       = year_in;
               result.month      = month_in;
               result.day        = day_in;
               result.hour       = hour_in;
               result.minute     = minute_in;
               result.second     = second_in;
               result.has_time   = flags_in[itsp_pkg::FL_TIME];
               result.has_zone   = flags_in[itsp_pkg::FL_ZONE];
               result.zone_was_z = flags_in[itsp_pkg::FL_Z];
               result.offset_seconds = flags_in[itsp_pkg::FL_NEG] ? -mag : mag;
            end
            phase_in  = itsp_pkg::PH_LEAD;
            year_in   = '0;
            month_in  = '0;
            day_in    = '0;
            hour_in   = '0;
            minute_in = '0;
            second_in = '0;
            zh_in     = '0;
            zm_in     = '0;
            flags_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= itsp_pkg::PH_LEAD;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         zh_ff     <= '0;
         zm_ff     <= '0;
         flags_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         zh_ff     <= zh_in;
         zm_ff     <= zm_in;
         flags_ff  <= flags_in;
      end
   end

`ifndef ASSERT_OFF
   // a string end always returns the parser to its start phase
   a_restart: assert property (@(posedge clock) disable iff (reset)
      take && in_data.last_char |=> phase_ff == itsp_pkg::PH_LEAD)
      else $error("parser did not restart after string end");

   // while still skipping leading whitespace nothing has been collected
   a_lead_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == itsp_pkg::PH_LEAD |-> year_ff == '0 && month_ff == '0 &&
      day_ff == '0 && hour_ff == '0 && zh_ff == '0 && zm_ff == '0 && flags_ff == '0)
      else $error("state not clean in lead phase");
`endif

endmodule

FILE: rtl/itsp_out_reg.sv
// result register with valid/stall handshake
module itsp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  itsp_pkg::rsp_type load_data,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itsp_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   itsp_pkg::rsp_type data_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: rtl/iso_timestamp_stream_parser_top.sv
// top level of the streaming timestamp parser
// path: a byte is held in the input register and parsed from there; a last byte's
//    result is loaded into the result register once that register is free
// throughput: one byte per cycle, except while a last byte waits on a stalled result;
//    the parse step lies between the input register and the result register
// reset: synchronous, clears handshake state and returns the parser to its start phase
module iso_timestamp_stream_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  itsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output itsp_pkg::rsp_type rsp_data
);

   // input register
   logic              ibuf_valid_ff, ibuf_valid_in;
   itsp_pkg::req_type ibuf_data_ff;

   logic              out_free;
   logic              take;
   logic              load;
   itsp_pkg::rsp_type result;

   // a byte without the last flag never needs the result register,
   // so only a last byte can wait on a stalled result
   assign take      = ibuf_valid_ff && (!ibuf_data_ff.last_char || out_free);
   assign load      = take && ibuf_data_ff.last_char;
   assign req_stall = ibuf_valid_ff && !take;

   // input register refills whenever its byte moves on or it is empty
   assign ibuf_valid_in = req_stall ? ibuf_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         ibuf_valid_ff <= 1'b0;
      end else begin
         ibuf_valid_ff <= ibuf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         ibuf_data_ff <= req_data;
      end
   end

   // parse step: phase machine plus field accumulators
   itsp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_data (ibuf_data_ff),
      .result  (result)
   );

   // result register toward the consumer
   itsp_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // input side only backs up behind a last byte waiting on a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ibuf_data_ff.last_char && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // a result transaction that completes is either replaced or retired
   a_result_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !load |=> !rsp_valid)
      else $error("result repeated after transaction");
`endif

endmodule
